// File: hw/rtl/gcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gcd_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 20;
  localparam int CORDIC_STAGES_DEF = 24;

  localparam int LAT_W = 28;
  localparam int LON_W = 29;
  localparam int RAD_W = 23;
  localparam int DIST_W = 25;

  // CORDIC datapath width, Q30 with headroom for gain and angle sums.
  localparam int CW = 34;
  // Width of the haversine term a, which lies in [0, 2^30].
  localparam int SQ_W = 31;

  localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 23'd6371000;
  localparam logic [DIST_W-1:0] DIST_MAX = 25'd26353590;

  function automatic logic [29:0] atan_q30(input int idx);
    logic [29:0] v;
    case (idx)
      0: v = 30'd843314856;
      1: v = 30'd497837829;
      2: v = 30'd263043836;
      3: v = 30'd133525158;
      4: v = 30'd67021686;
      5: v = 30'd33543515;
      6: v = 30'd16775850;
      7: v = 30'd8388437;
      8: v = 30'd4194282;
      9: v = 30'd2097149;
      10: v = 30'd1048575;
      11: v = 30'd524287;
      12: v = 30'd262143;
      13: v = 30'd131071;
      14: v = 30'd65535;
      15: v = 30'd32767;
      16: v = 30'd16383;
      17: v = 30'd8191;
      18: v = 30'd4095;
      19: v = 30'd2047;
      20: v = 30'd1023;
      21: v = 30'd511;
      22: v = 30'd255;
      23: v = 30'd127;
      24: v = 30'd63;
      25: v = 30'd31;
      26: v = 30'd15;
      27: v = 30'd7;
      28: v = 30'd3;
      29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/gcd_angle.sv
`timescale 1ns / 1ps
`default_nettype none
module gcd_angle
  import gcd_pkg::*;
#(
  parameter int FRAC = ANGLE_FRAC_BITS_DEF,
  parameter int IN_W = 29,
  parameter int HALF_ANG = 0,
  parameter int FOLD = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   adv,
  input  wire logic                   vld_i,
  input  wire logic signed [IN_W-1:0] ang_i,
  output logic                        vld_o,
  output logic signed [CW-1:0]        rad_o,
  output logic                        neg_o
);

  localparam longint FULL = longint'(360) << FRAC;
  localparam longint HALF_C = FULL / 2;
  localparam longint QUARTER = FULL / 4;
  localparam longint MULT = (longint'(1) << (IN_W - 1)) / FULL + 1;
  localparam longint OFF = HALF_C + MULT * FULL;
  localparam int VW = 33;
  localparam longint RECIP = (longint'(1) << VW) / FULL;
  localparam int RW = $clog2(RECIP + 1);
  localparam int PW = VW + 28;
  localparam int SH = FRAC + 2 + HALF_ANG;

  localparam logic [VW-1:0] FULL_V = VW'(FULL);
  localparam logic [VW-1:0] HALF_V = VW'(HALF_C);
  localparam logic signed [VW-1:0] QUARTER_V = VW'(QUARTER);
  localparam logic [RW-1:0] RECIP_V = RW'(RECIP);

  logic [5:0]            v_r;
  logic [VW-1:0]         v1_r, v2_r, r3_r;
  logic [RW-1:0]         q2_r;
  logic signed [VW-1:0]  a4_r;
  logic [2:0]            n_r;
  logic signed [PW-1:0]  p5_r;
  logic signed [CW-1:0]  rad_r;

  logic [VW+RW-1:0]      prod2;
  logic [VW-1:0]         qf3, rr4;
  logic signed [VW-1:0]  rc4, ab4, a4_nxt;
  logic                  n4_nxt;
  logic signed [PW-1:0]  rnd6, sh6;

  assign prod2 = v1_r * RECIP_V;
  assign qf3 = q2_r * FULL_V;
  assign rr4 = (r3_r >= FULL_V) ? (r3_r - FULL_V) : r3_r;
  assign rc4 = $signed(rr4 - HALF_V);
  assign ab4 = (rc4 < 0) ? -rc4 : rc4;

  always_comb begin
    a4_nxt = rc4;
    n4_nxt = 1'b0;
    if (FOLD != 0) begin
      a4_nxt = ab4;
      if (ab4 > QUARTER_V) begin
        a4_nxt = $signed(HALF_V) - ab4;
        n4_nxt = 1'b1;
      end
    end
  end

  assign rnd6 = p5_r + (PW'(1) <<< (SH - 1));
  assign sh6 = rnd6 >>> SH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v1_r <= VW'(longint'(ang_i) + OFF);
      q2_r <= prod2[VW+RW-1:VW];
      v2_r <= v1_r;
      r3_r <= v2_r - qf3;
      a4_r <= a4_nxt;
      n_r[0] <= n4_nxt;
      p5_r <= a4_r * $signed({1'b0, DEG_TO_RAD_Q32});
      n_r[1] <= n_r[0];
      rad_r <= sh6[CW-1:0];
      n_r[2] <= n_r[1];
    end
  end

  assign vld_o = v_r[5];
  assign rad_o = rad_r;
  assign neg_o = n_r[2];

endmodule
`default_nettype wire

// File: hw/rtl/gcd_cordic_rot.sv
`timescale 1ns / 1ps
`default_nettype none
module gcd_cordic_rot
  import gcd_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF,
  parameter int SEL_SIN = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic                 vld_i,
  input  wire logic signed [CW-1:0] z_i,
  input  wire logic                 neg_i,
  output logic                      vld_o,
  output logic signed [CW-1:0]      res_o
);

  logic signed [CW-1:0] x_r [0:STAGES-1];
  logic signed [CW-1:0] y_r [0:STAGES-1];
  logic signed [CW-1:0] z_r [0:STAGES-1];
  logic [STAGES-1:0]    v_r;
  logic [STAGES-1:0]    n_r;

  for (genvar i = 0; i < STAGES; i++) begin : g_st
    localparam logic signed [CW-1:0] ATN = $signed(CW'(atan_q30(i)));
    logic signed [CW-1:0] xi, yi, zi;
    logic vi, ni;
    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN_Q30;
      assign yi = '0;
      assign zi = z_i;
      assign vi = vld_i;
      assign ni = neg_i;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign vi = v_r[i-1];
      assign ni = n_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        n_r[i] <= ni;
        if (zi >= 0) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - ATN;
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + ATN;
        end
      end
    end
  end

  assign vld_o = v_r[STAGES-1];
  assign res_o = (SEL_SIN != 0) ? y_r[STAGES-1] :
                 (n_r[STAGES-1] ? -x_r[STAGES-1] : x_r[STAGES-1]);

endmodule
`default_nettype wire

// File: hw/rtl/gcd_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module gcd_sqrt
  import gcd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            vld_i,
  input  wire logic [SQ_W-1:0] a_i,
  output logic                 vld_o,
  output logic [SQ_W-1:0]      root_o
);

  localparam int NW = 2 * SQ_W - 1;

  logic [NW-1:0]   n_r   [0:SQ_W-1];
  logic [NW-1:0]   res_r [0:SQ_W-1];
  logic [SQ_W-1:0] v_r;

  for (genvar i = 0; i < SQ_W; i++) begin : g_st
    localparam logic [NW-1:0] BIT = NW'(1) << (2 * (SQ_W - 1 - i));
    logic [NW-1:0] ni, ri;
    logic [NW:0]   sum;
    logic          vi;
    if (i == 0) begin : g_first
      assign ni = {a_i, (SQ_W - 1)'(0)};
      assign ri = '0;
      assign vi = vld_i;
    end else begin : g_next
      assign ni = n_r[i-1];
      assign ri = res_r[i-1];
      assign vi = v_r[i-1];
    end
    assign sum = {1'b0, ri} + {1'b0, BIT};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if ({1'b0, ni} >= sum) begin
          n_r[i] <= ni - sum[NW-1:0];
          res_r[i] <= (ri >> 1) + BIT;
        end else begin
          n_r[i] <= ni;
          res_r[i] <= ri >> 1;
        end
      end
    end
  end

  assign vld_o = v_r[SQ_W-1];
  assign root_o = res_r[SQ_W-1][SQ_W-1:0];

endmodule
`default_nettype wire

// File: hw/rtl/gcd_cordic_vec.sv
`timescale 1ns / 1ps
`default_nettype none
module gcd_cordic_vec
  import gcd_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic                 vld_i,
  input  wire logic signed [CW-1:0] x_i,
  input  wire logic signed [CW-1:0] y_i,
  output logic                      vld_o,
  output logic signed [CW-1:0]      z_o
);

  logic signed [CW-1:0] x_r [0:STAGES-1];
  logic signed [CW-1:0] y_r [0:STAGES-1];
  logic signed [CW-1:0] z_r [0:STAGES-1];
  logic [STAGES-1:0]    v_r;

  for (genvar i = 0; i < STAGES; i++) begin : g_st
    localparam logic signed [CW-1:0] ATN = $signed(CW'(atan_q30(i)));
    logic signed [CW-1:0] xi, yi, zi;
    logic vi;
    if (i == 0) begin : g_first
      assign xi = x_i;
      assign yi = y_i;
      assign zi = '0;
      assign vi = vld_i;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign vi = v_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (yi > 0) begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + ATN;
        end else begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - ATN;
        end
      end
    end
  end

  assign vld_o = v_r[STAGES-1];
  assign z_o = z_r[STAGES-1];

endmodule
`default_nettype wire

// File: hw/rtl/great_circle_distance.sv
// Haversine great-circle distance between two points on a sphere.
// The input stream carries one pair of points per beat: both latitudes and
// longitudes in signed fixed point. The result stream carries one beat per
// input beat, in the same order: the distance in whole meters, rounded and
// saturated. The sphere radius is set through a single write-only register.
// The datapath is a fully pipelined chain: angle reduction and conversion to
// radians (6 stages), rotation CORDIC (CORDIC_STAGES), three product stages,
// a bit-serial square root unrolled into 31 stages, vectoring CORDIC
// (CORDIC_STAGES), one radius multiply stage and the output register.
// Throughput is one beat per cycle while no beat waits in the spare output
// entry. All stages advance together; a two-entry output buffer catches the
// last beat the pipeline pushes once the receiver drops out_tready, and
// in_tready is a registered flag of that buffer.
// Items are held, never dropped or repeated, while the receiver stalls.
// Reset empties the pipeline and loads the radius with 6371000 meters.
// The radius may be written only while no beat is in flight.
`timescale 1ns / 1ps
`default_nettype none
module great_circle_distance
  import gcd_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // first_latitude, first_longitude, second_latitude, second_longitude
  input  wire logic [119:0]      in_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // distance_m
  output logic [31:0]            out_tdata,
  input  wire logic              cfg_we,
  input  wire logic [RAD_W-1:0]  cfg_wdata
);

  function automatic logic signed [32:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] t;
    t = (64'(a) * 64'(b) + 64'sd536870912) >>> 30;
    return t[32:0];
  endfunction

  logic [RAD_W-1:0] radius_r;
  logic adv, accept;

  logic signed [LAT_W-1:0] lat1, lat2;
  logic signed [LON_W-1:0] lon1, lon2;
  logic signed [LAT_W:0]   dlat;
  logic signed [LON_W:0]   dlon;

  logic ang_v;
  logic signed [CW-1:0] r_dlat, r_dlon, r_lat1, r_lat2;
  logic n_lat1, n_lat2;
  logic rot_v;
  logic signed [CW-1:0] s_dlat, s_dlon, c_lat1, c_lat2;

  logic p1_v_r, p2_v_r, p3_v_r;
  logic signed [32:0] sdp1_r, sdl1_r, cc1_r, sdp2_r, t2_r;
  logic [SQ_W-1:0] a3_r, b3_r;
  logic signed [33:0] asum;

  logic sq_v;
  logic [SQ_W-1:0] root_a, root_b;
  logic vec_v;
  logic signed [CW-1:0] ang_z;

  logic f1_v_r;
  logic signed [RAD_W+CW+1:0] prod_r;
  logic signed [RAD_W+CW+1:0] drnd;
  logic [DIST_W-1:0] push_data;

  logic out_valid_r, spare_v_r;
  logic [DIST_W-1:0] out_data_r, spare_r;
  logic push;

  localparam logic [SQ_W-1:0] ONE_Q30 = SQ_W'(1) << 30;

  assign lat1 = in_tdata[27:0];
  assign lon1 = in_tdata[56:28];
  assign lat2 = in_tdata[84:57];
  assign lon2 = in_tdata[113:85];
  assign dlat = {lat2[LAT_W-1], lat2} - {lat1[LAT_W-1], lat1};
  assign dlon = {lon2[LON_W-1], lon2} - {lon1[LON_W-1], lon1};

  assign adv = !spare_v_r;
  assign in_tready = adv;
  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  gcd_angle #(.FRAC(ANGLE_FRAC_BITS), .IN_W(LAT_W + 1), .HALF_ANG(1), .FOLD(0)) u_ang_dlat (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_i(accept), .ang_i(dlat),
    .vld_o(ang_v), .rad_o(r_dlat), .neg_o()
  );
  gcd_angle #(.FRAC(ANGLE_FRAC_BITS), .IN_W(LON_W + 1), .HALF_ANG(1), .FOLD(0)) u_ang_dlon (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_i(accept), .ang_i(dlon),
    .vld_o(), .rad_o(r_dlon), .neg_o()
  );
  gcd_angle #(.FRAC(ANGLE_FRAC_BITS), .IN_W(LAT_W), .HALF_ANG(0), .FOLD(1)) u_ang_lat1 (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_i(accept), .ang_i(lat1),
    .vld_o(), .rad_o(r_lat1), .neg_o(n_lat1)
  );
  gcd_angle #(.FRAC(ANGLE_FRAC_BITS), .IN_W(LAT_W), .HALF_ANG(0), .FOLD(1)) u_ang_lat2 (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_i(accept), .ang_i(lat2),
    .vld_o(), .rad_o(r_lat2), .neg_o(n_lat2)
  );

  gcd_cordic_rot #(.STAGES(CORDIC_STAGES), .SEL_SIN(1)) u_rot_dlat (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_i(ang_v), .z_i(r_dlat), .neg_i(1'b0),
    .vld_o(rot_v), .res_o(s_dlat)
  );
  gcd_cordic_rot #(.STAGES(CORDIC_STAGES), .SEL_SIN(1)) u_rot_dlon (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_i(ang_v), .z_i(r_dlon), .neg_i(1'b0),
    .vld_o(), .res_o(s_dlon)
  );
  gcd_cordic_rot #(.STAGES(CORDIC_STAGES), .SEL_SIN(0)) u_rot_lat1 (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_i(ang_v), .z_i(r_lat1), .neg_i(n_lat1),
    .vld_o(), .res_o(c_lat1)
  );
  gcd_cordic_rot #(.STAGES(CORDIC_STAGES), .SEL_SIN(0)) u_rot_lat2 (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_i(ang_v), .z_i(r_lat2), .neg_i(n_lat2),
    .vld_o(), .res_o(c_lat2)
  );

  assign asum = {sdp2_r[32], sdp2_r} + {t2_r[32], t2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r <= rot_v;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sdp1_r <= mul_q30(s_dlat[31:0], s_dlat[31:0]);
      sdl1_r <= mul_q30(s_dlon[31:0], s_dlon[31:0]);
      cc1_r <= mul_q30(c_lat1[31:0], c_lat2[31:0]);
      sdp2_r <= sdp1_r;
      t2_r <= mul_q30(cc1_r[31:0], sdl1_r[31:0]);
      if (asum < 0) begin
        a3_r <= '0;
        b3_r <= ONE_Q30;
      end else if (asum > $signed({3'b000, ONE_Q30})) begin
        a3_r <= ONE_Q30;
        b3_r <= '0;
      end else begin
        a3_r <= asum[SQ_W-1:0];
        b3_r <= ONE_Q30 - asum[SQ_W-1:0];
      end
    end
  end

  gcd_sqrt u_sqrt_a (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_i(p3_v_r), .a_i(a3_r),
    .vld_o(sq_v), .root_o(root_a)
  );
  gcd_sqrt u_sqrt_b (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_i(p3_v_r), .a_i(b3_r),
    .vld_o(), .root_o(root_b)
  );

  gcd_cordic_vec #(.STAGES(CORDIC_STAGES)) u_vec (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_i(sq_v),
    .x_i($signed({(CW - SQ_W)'(0), root_b})), .y_i($signed({(CW - SQ_W)'(0), root_a})),
    .vld_o(vec_v), .z_o(ang_z)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= vec_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= $signed({1'b0, radius_r}) * $signed({ang_z, 1'b0});
    end
  end

  assign drnd = (prod_r + (($bits(prod_r))'(1) <<< 29)) >>> 30;

  always_comb begin
    if (drnd < 0) begin
      push_data = '0;
    end else if (drnd > $signed({{($bits(drnd) - DIST_W){1'b0}}, DIST_MAX})) begin
      push_data = DIST_MAX;
    end else begin
      push_data = drnd[DIST_W-1:0];
    end
  end

  assign push = adv && f1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      spare_v_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (spare_v_r) begin
        out_valid_r <= 1'b1;
        spare_v_r <= push;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      spare_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (spare_v_r) begin
        out_data_r <= spare_r;
        spare_r <= push_data;
      end else begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      spare_r <= push_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {{(32 - DIST_W){1'b0}}, out_data_r};

  a_spare_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    spare_v_r |-> out_valid_r)
    else $error("Output buffer holds a second beat without a first one.");

  a_spare_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (spare_v_r && !out_tready) |=> (spare_v_r && $stable(spare_r)))
    else $error("Buffered beat was lost while the receiver stalled.");

  a_a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    p3_v_r |-> (a3_r <= ONE_Q30 && (a3_r + b3_r) == ONE_Q30))
    else $error("Haversine term left its clamped range.");

  a_dist_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r <= DIST_MAX))
    else $error("Distance above the saturation limit.");

endmodule
`default_nettype wire

// File: tb/great_circle_distance_tb.sv
`timescale 1ns / 1ps
module great_circle_distance_tb;
  import gcd_pkg::*;

  localparam int FRAC = ANGLE_FRAC_BITS_DEF;
  localparam int STAGES = CORDIC_STAGES_DEF;
  localparam int LATENCY = 2 * STAGES + 42;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint FULL_TURN = longint'(360) <<< FRAC;
  localparam longint HALF_TURN = longint'(180) <<< FRAC;
  localparam longint LAT_MAX = 94371840;
  localparam longint LON_MAX = 188743680;
  localparam longint ONE_Q30 = longint'(1) <<< 30;

  typedef struct packed {
    logic signed [LON_W-1:0] lon2;
    logic signed [LAT_W-1:0] lat2;
    logic signed [LON_W-1:0] lon1;
    logic signed [LAT_W-1:0] lat1;
  } point_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [119:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [RAD_W-1:0] cfg_wdata = '0;

  point_pair_t pending_pairs[$];
  logic [DIST_W-1:0] expected_distances[$];
  logic [RAD_W-1:0] radius_m;
  bit hold_off = 1'b0;
  bit calm = 1'b0;
  int failures = 0;
  int beats_in = 0;
  int beats_out = 0;
  int quiet_cycles = 0;

  great_circle_distance dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint floor_div2(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_div2(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return round_div2(a * b, 30);
  endfunction

  function automatic longint wrap_angle(longint u);
    longint r;
    r = u % FULL_TURN;
    if (r >= FULL_TURN / 2) r -= FULL_TURN;
    if (r < -(FULL_TURN / 2)) r += FULL_TURN;
    return r;
  endfunction

  function automatic longint deg_to_rad(longint u, int extra);
    return round_div2(u * 74961321, FRAC + 2 + extra);
  endfunction

  function automatic void rotate(longint z, output longint s, output longint c);
    longint x, y, dx, dy;
    x = 652032874;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = floor_div2(y, i);
      dy = floor_div2(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q30(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q30(i));
      end
    end
    s = y;
    c = x;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = floor_div2(y, i);
      dy = floor_div2(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(atan_q30(i));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_q30(i));
      end
    end
    return z;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint latitude_cos(longint u);
    longint r, s, c;
    bit neg;
    neg = 1'b0;
    r = wrap_angle(u);
    if (r < 0) r = -r;
    if (r > HALF_TURN / 2) begin
      r = HALF_TURN - r;
      neg = 1'b1;
    end
    rotate(deg_to_rad(r, 0), s, c);
    return neg ? -c : c;
  endfunction

  function automatic longint half_sine_squared(longint du);
    longint s, c;
    rotate(deg_to_rad(wrap_angle(du), 1), s, c);
    return q30_mul(s, s);
  endfunction

  function automatic logic [DIST_W-1:0] predict_distance(point_pair_t p,
                                                          logic [RAD_W-1:0] r);
    longint a, ra, rb, c, d;
    a = half_sine_squared(longint'(p.lat2) - longint'(p.lat1))
        + q30_mul(q30_mul(latitude_cos(p.lat1), latitude_cos(p.lat2)),
                  half_sine_squared(longint'(p.lon2) - longint'(p.lon1)));
    if (a < 0) a = 0;
    if (a > ONE_Q30) a = ONE_Q30;
    ra = int_sqrt(longint'(a) <<< 30);
    rb = int_sqrt(longint'(ONE_Q30 - a) <<< 30);
    c = 2 * vector_angle(ra, rb);
    d = round_div2(longint'(r) * c, 30);
    if (d < 0) d = 0;
    if (d > longint'(DIST_MAX)) d = DIST_MAX;
    return d[DIST_W-1:0];
  endfunction

  function automatic longint pick(longint lim);
    case ($urandom_range(9))
      0: return lim;
      1: return -lim;
      2: return longint'($urandom_range(2000)) - 1000;
      default: return longint'($urandom_range(2 * lim)) - lim;
    endcase
  endfunction

  function automatic point_pair_t random_pair();
    point_pair_t p;
    p.lat1 = LAT_W'(pick(LAT_MAX));
    p.lon1 = LON_W'(pick(LON_MAX));
    if ($urandom_range(3) == 0) begin
      p.lat2 = LAT_W'(longint'(p.lat1) + longint'($urandom_range(4000)) - 2000);
      p.lon2 = LON_W'(longint'(p.lon1) + longint'($urandom_range(4000)) - 2000);
    end else if ($urandom_range(7) == 0) begin
      p.lat2 = -p.lat1;
      p.lon2 = LON_W'(longint'(p.lon1) + HALF_TURN);
    end else begin
      p.lat2 = LAT_W'(pick(LAT_MAX));
      p.lon2 = LON_W'(pick(LON_MAX));
    end
    return p;
  endfunction

  function automatic point_pair_t make_pair(longint a, longint b, longint c, longint d);
    point_pair_t p;
    p.lat1 = LAT_W'(a); p.lon1 = LON_W'(b); p.lat2 = LAT_W'(c); p.lon2 = LON_W'(d);
    return p;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_distances.push_back(predict_distance(point_pair_t'(in_tdata[113:0]),
                                                      radius_m));
        beats_in++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (pending_pairs.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
          in_tvalid <= 1'b1;
          in_tdata <= {6'b000000, pending_pairs.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic [DIST_W-1:0] want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        beats_out++;
        if (expected_distances.size() == 0) begin
          $error("distance_m: unexpected beat, actual %0d", out_tdata[DIST_W-1:0]);
          failures++;
        end else begin
          want = expected_distances.pop_front();
          if (out_tdata[DIST_W-1:0] !== want) begin
            $error("distance_m: expected %0d, actual %0d", want, out_tdata[DIST_W-1:0]);
            failures++;
          end
        end
      end
      out_tready <= !hold_off && (calm || $urandom_range(99) >= 31);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic drain();
    while (pending_pairs.size() > 0 || in_tvalid || expected_distances.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_radius(logic [RAD_W-1:0] r);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    radius_m = r;
  endtask

  initial begin
    logic [RAD_W-1:0] radii[5];
    radii = '{23'd1, 23'h7FFFFF, 23'd0, 23'd1000, RADIUS_RESET};
    radius_m = RADIUS_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    pending_pairs.push_back(make_pair(0, 0, 0, 0));
    pending_pairs.push_back(make_pair(LAT_MAX, 0, -LAT_MAX, 0));
    pending_pairs.push_back(make_pair(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX));
    pending_pairs.push_back(make_pair(0, -LON_MAX, 0, LON_MAX));
    pending_pairs.push_back(make_pair(0, 0, 0, HALF_TURN));
    pending_pairs.push_back(make_pair(0, 0, 0, -HALF_TURN));
    pending_pairs.push_back(make_pair(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX));
    pending_pairs.push_back(make_pair(-(longint'(1) <<< 27), -(longint'(1) <<< 28),
                                      (longint'(1) <<< 27) - 1, (longint'(1) <<< 28) - 1));
    pending_pairs.push_back(make_pair((longint'(1) <<< 27) - 1, 0, 0, 0));
    pending_pairs.push_back(make_pair(longint'(100) <<< FRAC, 0, longint'(80) <<< FRAC, 0));
    pending_pairs.push_back(make_pair(longint'(-135) <<< FRAC, longint'(400) <<< FRAC,
                                      longint'(45) <<< FRAC, longint'(-500) <<< FRAC));
    pending_pairs.push_back(make_pair(1, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 1));
    pending_pairs.push_back(make_pair(0, 0, LAT_MAX / 2, LON_MAX / 2));
    drain();
    set_radius(23'h7FFFFF);
    pending_pairs.push_back(make_pair(0, 0, 0, HALF_TURN));
    pending_pairs.push_back(make_pair(LAT_MAX, 0, -LAT_MAX, 0));
    drain();
    calm = 1'b1;
    for (int i = 0; i < 150; i++) pending_pairs.push_back(random_pair());
    hold_off = 1'b1;
    repeat (LATENCY + 200) @(posedge clk);
    hold_off = 1'b0;
    drain();
    calm = 1'b0;
    foreach (radii[k]) begin
      set_radius(radii[k]);
      for (int i = 0; i < 100; i++) pending_pairs.push_back(random_pair());
      drain();
    end
    $display("Sent %0d point pairs and checked %0d distances across several radius values.",
             beats_in, beats_out);
    if (failures == 0 && expected_distances.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
